// ===== sv/mis_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the merge-insertion sorter.
// Used by the controller, the datapath, the top level and the checker.
package mis_pkg;

  localparam int MAX_ITEMS_DEF = 64;
  localparam int VALUE_W       = 32;

  // One datapath operation per cycle, issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_PAIR_START,
    OP_LVL_UP,
    OP_LVL_DOWN,
    OP_RD_PAIR,
    OP_PAIR_NEXT,
    OP_WR_A,
    OP_WR_B,
    OP_WR_B_END,
    OP_RD_CHAIN_SRC,
    OP_WR_CHAIN,
    OP_RD_KEY,
    OP_KEY_FRONT,
    OP_KEY_SEARCH,
    OP_RD_MID,
    OP_STEP,
    OP_SEARCH_DONE,
    OP_RD_SHIFT,
    OP_WR_SHIFT,
    OP_PLACE_START,
    OP_RD_PLACE,
    OP_WR_PLACE,
    OP_WR_PLACE_END,
    OP_BACK_START,
    OP_RD_BACK,
    OP_WR_BACK,
    OP_OUT_START,
    OP_RD_OUT,
    OP_OUT_NEXT,
    OP_OUT_END
  } op_e;

  // Loop and compare flags reported back to the controller
  typedef struct packed {
    logic active;       // current level still has more than one group
    logic lvl_zero;     // at the finest level (group width one)
    logic pair_more;    // another full pair remains in the pairing pass
    logic pair_lt;      // first lead below second lead
    logic elem_last;    // element index at last place of a group
    logic chain_last;   // last element of the main chain being built
    logic ins_more;     // chain not yet complete, a pending group remains
    logic key_front;    // key below the chain head
    logic search_more;  // binary search window wider than one
    logic shift_more;   // chain entries left to move up
    logic back_last;    // last word of the write back
    logic out_last;     // last word of the sorted run
  } dp_status_t;

endpackage

// ===== sv/mis_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the merge-insertion sorter: value and chain memories,
// loop counters and comparators. Depends on mis_pkg.
module mis_datapath #(
  parameter int MAX_ITEMS = mis_pkg::MAX_ITEMS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  mis_pkg::op_e                         op_i,
  input  logic signed [mis_pkg::VALUE_W-1:0]   in_value_i,
  output mis_pkg::dp_status_t                  status_o,
  output logic signed [mis_pkg::VALUE_W-1:0]   out_value_o,
  output logic                                 out_last_o,
  output logic                                 out_ovf_o
);
  import mis_pkg::*;

  localparam int AW  = $clog2(MAX_ITEMS);
  localparam int CW  = $clog2(MAX_ITEMS + 1);
  localparam int LGW = $clog2(AW + 1);
  localparam logic [CW-1:0] ONES    = '1;
  localparam logic [CW-1:0] ONE     = CW'(1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

  // Memories
  logic signed [VALUE_W-1:0] value_mem [MAX_ITEMS];
  logic signed [VALUE_W-1:0] chain_mem [MAX_ITEMS];

  // Registered read data
  logic signed [VALUE_W-1:0] va_q, vb_q, cr_q;

  // Control registers
  logic [CW-1:0]  cnt_q, pos_q, idx_q, clen_q, p_q, lo_q, hi_q, at_q;
  logic [LGW-1:0] lg_q;
  logic           ovf_q;

  // Level geometry
  logic [CW-1:0]  w, nw, full, half, pairs, start, src, mid, mid_addr;
  logic [LGW:0]   lg1;
  logic [CW:0]    mid_sum;

  // Memory port controls
  logic          va_re, vb_re, cr_re, vm_we, cm_we;
  logic [CW-1:0] va_ra, vb_ra, cr_ra, vm_wa, cm_wa;
  logic signed [VALUE_W-1:0] vm_wd, cm_wd;

  // Derive group width, level sizes and addresses from the level index
  always_comb begin
    w        = ONE << lg_q;
    lg1      = {1'b0, lg_q} + (LGW + 1)'(1);
    nw       = cnt_q & (ONES << lg_q);
    full     = cnt_q & (ONES << lg1);
    half     = full >> 1;
    pairs    = full >> lg1;
    start    = (p_q < pairs) ? (((p_q << 1) | ONE) << lg_q) : full;
    src      = ((clen_q >> lg_q) << lg1) | (clen_q & (w - ONE));
    mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
    mid      = mid_sum[CW:1];
    mid_addr = mid << lg_q;
  end

  // Decode memory accesses for the current operation
  always_comb begin
    va_re = 1'b0;
    vb_re = 1'b0;
    cr_re = 1'b0;
    vm_we = 1'b0;
    cm_we = 1'b0;
    va_ra = '0;
    vb_ra = pos_q + w + idx_q;
    cr_ra = '0;
    vm_wa = '0;
    cm_wa = '0;
    vm_wd = va_q;
    cm_wd = va_q;
    case (op_i)
      OP_LOAD: begin
        vm_we = (cnt_q < MAX_CNT);
        vm_wa = cnt_q;
        vm_wd = in_value_i;
      end
      OP_RD_PAIR: begin
        va_re = 1'b1;
        vb_re = 1'b1;
        va_ra = pos_q + idx_q;
      end
      OP_WR_A: begin
        vm_we = 1'b1;
        vm_wa = pos_q + idx_q;
        vm_wd = vb_q;
      end
      OP_WR_B, OP_WR_B_END: begin
        vm_we = 1'b1;
        vm_wa = pos_q + w + idx_q;
      end
      OP_RD_CHAIN_SRC: begin
        va_re = 1'b1;
        va_ra = src;
      end
      OP_WR_CHAIN: begin
        cm_we = 1'b1;
        cm_wa = clen_q;
      end
      OP_RD_KEY: begin
        va_re = 1'b1;
        va_ra = start;
        cr_re = 1'b1;
      end
      OP_RD_MID: begin
        cr_re = 1'b1;
        cr_ra = mid_addr;
      end
      OP_RD_SHIFT: begin
        cr_re = 1'b1;
        cr_ra = idx_q - ONE;
      end
      OP_WR_SHIFT: begin
        cm_we = 1'b1;
        cm_wa = idx_q - ONE + w;
        cm_wd = cr_q;
      end
      OP_RD_PLACE: begin
        va_re = 1'b1;
        va_ra = start + idx_q;
      end
      OP_WR_PLACE, OP_WR_PLACE_END: begin
        cm_we = 1'b1;
        cm_wa = at_q + idx_q;
      end
      OP_RD_BACK: begin
        cr_re = 1'b1;
        cr_ra = idx_q;
      end
      OP_WR_BACK: begin
        vm_we = 1'b1;
        vm_wa = idx_q;
        vm_wd = cr_q;
      end
      OP_RD_OUT: begin
        va_re = 1'b1;
        va_ra = idx_q;
      end
      default: begin
      end
    endcase
  end

  // Value memory, two read ports
  always_ff @(posedge clk_i) begin
    if (vm_we) begin
      value_mem[vm_wa[AW-1:0]] <= vm_wd;
    end
    if (va_re) begin
      va_q <= value_mem[va_ra[AW-1:0]];
    end
    if (vb_re) begin
      vb_q <= value_mem[vb_ra[AW-1:0]];
    end
  end

  // Chain memory, one read port
  always_ff @(posedge clk_i) begin
    if (cm_we) begin
      chain_mem[cm_wa[AW-1:0]] <= cm_wd;
    end
    if (cr_re) begin
      cr_q <= chain_mem[cr_ra[AW-1:0]];
    end
  end

  // Advance counters, level and search window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
      lg_q   <= '0;
      pos_q  <= '0;
      idx_q  <= '0;
      clen_q <= '0;
      p_q    <= '0;
      lo_q   <= '0;
      hi_q   <= '0;
      at_q   <= '0;
    end else begin
      case (op_i)
        OP_LOAD: begin
          if (cnt_q < MAX_CNT) begin
            cnt_q <= cnt_q + ONE;
          end else begin
            ovf_q <= 1'b1;
          end
        end
        OP_PAIR_START: begin
          pos_q <= '0;
          idx_q <= '0;
        end
        OP_LVL_UP: lg_q <= lg_q + LGW'(1);
        OP_LVL_DOWN: begin
          lg_q   <= lg_q - LGW'(1);
          clen_q <= '0;
          p_q    <= '0;
        end
        OP_PAIR_NEXT, OP_WR_B_END: begin
          pos_q <= pos_q + (w << 1);
          idx_q <= '0;
        end
        OP_WR_B:     idx_q  <= idx_q + ONE;
        OP_WR_CHAIN: clen_q <= clen_q + ONE;
        OP_KEY_FRONT: begin
          at_q  <= '0;
          idx_q <= clen_q;
        end
        OP_KEY_SEARCH: begin
          lo_q <= '0;
          hi_q <= p_q << 1;
        end
        OP_STEP: begin
          if (cr_q < va_q) begin
            lo_q <= mid;
          end else begin
            hi_q <= mid;
          end
        end
        OP_SEARCH_DONE: begin
          at_q  <= hi_q << lg_q;
          idx_q <= clen_q;
        end
        OP_WR_SHIFT:    idx_q <= idx_q - ONE;
        OP_PLACE_START: idx_q <= '0;
        OP_WR_PLACE:    idx_q <= idx_q + ONE;
        OP_WR_PLACE_END: begin
          clen_q <= clen_q + w;
          p_q    <= p_q + ONE;
        end
        OP_BACK_START: idx_q <= '0;
        OP_WR_BACK:    idx_q <= idx_q + ONE;
        OP_OUT_START:  idx_q <= '0;
        OP_OUT_NEXT:   idx_q <= idx_q + ONE;
        OP_OUT_END: begin
          cnt_q <= '0;
          ovf_q <= 1'b0;
          lg_q  <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Report loop and compare flags
  always_comb begin
    status_o.active      = (nw > w);
    status_o.lvl_zero    = (lg_q == '0);
    status_o.pair_more   = (pos_q < full);
    status_o.pair_lt     = (va_q < vb_q);
    status_o.elem_last   = (idx_q == w - ONE);
    status_o.chain_last  = (clen_q + ONE == half);
    status_o.ins_more    = (clen_q < nw);
    status_o.key_front   = (va_q < cr_q);
    status_o.search_more = ((hi_q - lo_q) > ONE);
    status_o.shift_more  = (idx_q > at_q);
    status_o.back_last   = (idx_q + ONE == nw);
    status_o.out_last    = (idx_q + ONE == cnt_q);
  end

  assign out_value_o = va_q;
  assign out_last_o  = status_o.out_last;
  assign out_ovf_o   = ovf_q;

endmodule

// ===== sv/mis_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the merge-insertion sorter: sequences load, sort levels,
// insertion and output by issuing one datapath operation per cycle. Depends on mis_pkg.
module mis_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_last_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  mis_pkg::dp_status_t status_i,
  output mis_pkg::op_e        op_o
);
  import mis_pkg::*;

  typedef enum logic [4:0] {
    S_LOAD,
    S_DESC,
    S_PAIR_TEST,
    S_PAIR_CMP,
    S_SWAP_RD,
    S_SWAP_WA,
    S_SWAP_WB,
    S_CHAIN_RD,
    S_CHAIN_WR,
    S_INS_TEST,
    S_KEY_CMP,
    S_SEARCH,
    S_SEARCH_CMP,
    S_SHIFT_TEST,
    S_SHIFT_WR,
    S_PLACE_RD,
    S_PLACE_WR,
    S_BACK_RD,
    S_BACK_WR,
    S_LVL_END,
    S_OUT_RD,
    S_OUT_SHOW
  } state_e;

  state_e state_q, state_d;

  // Next state and operation
  always_comb begin
    state_d     = state_q;
    op_o        = OP_NONE;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_o = OP_LOAD;
          if (in_last_i) begin
            state_d = S_DESC;
          end
        end
      end
      // Descend: pair up groups while the level holds more than one group
      S_DESC: begin
        if (status_i.active) begin
          op_o    = OP_PAIR_START;
          state_d = S_PAIR_TEST;
        end else if (status_i.lvl_zero) begin
          op_o    = OP_OUT_START;
          state_d = S_OUT_RD;
        end else begin
          op_o    = OP_LVL_DOWN;
          state_d = S_CHAIN_RD;
        end
      end
      S_PAIR_TEST: begin
        if (status_i.pair_more) begin
          op_o    = OP_RD_PAIR;
          state_d = S_PAIR_CMP;
        end else begin
          op_o    = OP_LVL_UP;
          state_d = S_DESC;
        end
      end
      S_PAIR_CMP: begin
        if (status_i.pair_lt) begin
          state_d = S_SWAP_WA;
        end else begin
          op_o    = OP_PAIR_NEXT;
          state_d = S_PAIR_TEST;
        end
      end
      S_SWAP_RD: begin
        op_o    = OP_RD_PAIR;
        state_d = S_SWAP_WA;
      end
      S_SWAP_WA: begin
        op_o    = OP_WR_A;
        state_d = S_SWAP_WB;
      end
      S_SWAP_WB: begin
        if (status_i.elem_last) begin
          op_o    = OP_WR_B_END;
          state_d = S_PAIR_TEST;
        end else begin
          op_o    = OP_WR_B;
          state_d = S_SWAP_RD;
        end
      end
      // Ascend: build the main chain from the larger groups
      S_CHAIN_RD: begin
        op_o    = OP_RD_CHAIN_SRC;
        state_d = S_CHAIN_WR;
      end
      S_CHAIN_WR: begin
        op_o    = OP_WR_CHAIN;
        state_d = status_i.chain_last ? S_INS_TEST : S_CHAIN_RD;
      end
      S_INS_TEST: begin
        if (status_i.ins_more) begin
          op_o    = OP_RD_KEY;
          state_d = S_KEY_CMP;
        end else begin
          op_o    = OP_BACK_START;
          state_d = S_BACK_RD;
        end
      end
      S_KEY_CMP: begin
        if (status_i.key_front) begin
          op_o    = OP_KEY_FRONT;
          state_d = S_SHIFT_TEST;
        end else begin
          op_o    = OP_KEY_SEARCH;
          state_d = S_SEARCH;
        end
      end
      // Binary search over group leads, bounded by the partner
      S_SEARCH: begin
        if (status_i.search_more) begin
          op_o    = OP_RD_MID;
          state_d = S_SEARCH_CMP;
        end else begin
          op_o    = OP_SEARCH_DONE;
          state_d = S_SHIFT_TEST;
        end
      end
      S_SEARCH_CMP: begin
        op_o    = OP_STEP;
        state_d = S_SEARCH;
      end
      // Open a gap of one group, top entry first
      S_SHIFT_TEST: begin
        if (status_i.shift_more) begin
          op_o    = OP_RD_SHIFT;
          state_d = S_SHIFT_WR;
        end else begin
          op_o    = OP_PLACE_START;
          state_d = S_PLACE_RD;
        end
      end
      S_SHIFT_WR: begin
        op_o    = OP_WR_SHIFT;
        state_d = S_SHIFT_TEST;
      end
      S_PLACE_RD: begin
        op_o    = OP_RD_PLACE;
        state_d = S_PLACE_WR;
      end
      S_PLACE_WR: begin
        if (status_i.elem_last) begin
          op_o    = OP_WR_PLACE_END;
          state_d = S_INS_TEST;
        end else begin
          op_o    = OP_WR_PLACE;
          state_d = S_PLACE_RD;
        end
      end
      // Copy the finished chain back into the value store
      S_BACK_RD: begin
        op_o    = OP_RD_BACK;
        state_d = S_BACK_WR;
      end
      S_BACK_WR: begin
        op_o    = OP_WR_BACK;
        state_d = status_i.back_last ? S_LVL_END : S_BACK_RD;
      end
      S_LVL_END: begin
        if (status_i.lvl_zero) begin
          op_o    = OP_OUT_START;
          state_d = S_OUT_RD;
        end else begin
          op_o    = OP_LVL_DOWN;
          state_d = S_CHAIN_RD;
        end
      end
      // Stream out the sorted run
      S_OUT_RD: begin
        op_o    = OP_RD_OUT;
        state_d = S_OUT_SHOW;
      end
      S_OUT_SHOW: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (status_i.out_last) begin
            op_o    = OP_OUT_END;
            state_d = S_LOAD;
          end else begin
            op_o    = OP_OUT_NEXT;
            state_d = S_OUT_RD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/merge_insertion_sorter.sv =====
`timescale 1ns / 1ps
// Top level of the merge-insertion sorter: controller plus datapath.
// Depends on mis_pkg, mis_ctrl and mis_datapath.
//
//  channel  | dir | tdata            | tlast        | tuser
//  s_axis   | in  | [31:0] value     | last of set  | -
//  m_axis   | out | [31:0] sorted    | last of run  | [0] overflowed
//
// Loading accepts one word per cycle. On the last word the set of n values is
// sorted in place: per level, pairs of groups are compared and swapped, the
// main chain is built from the larger groups, and each pending group is
// inserted after a binary search over group leads (skipped when its key goes
// to the front), by moving chain words up and writing its own words; the chain
// is then written back, all chain moves through the single chain memory port.
// Each result word is read from the value store before it is offered. No input
// is taken while sorting or sending. Reset clears the count, the overflow flag
// and the level, not the memories. A stalled result holds on m_axis until taken.
module merge_insertion_sorter #(
  parameter int MAX_ITEMS = mis_pkg::MAX_ITEMS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic signed [mis_pkg::VALUE_W-1:0] s_axis_tdata,  // [31:0] item_value
  input  logic                               s_axis_tlast,  // last_item
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic signed [mis_pkg::VALUE_W-1:0] m_axis_tdata,  // [31:0] sorted_value
  output logic                               m_axis_tlast,  // last_of_run
  output logic                               m_axis_tuser   // [0] overflowed
);
  import mis_pkg::*;

  op_e        op;
  dp_status_t status;

  mis_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .op_o        (op)
  );

  mis_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .in_value_i  (s_axis_tdata),
    .status_o    (status),
    .out_value_o (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_ovf_o   (m_axis_tuser)
  );

endmodule

// ===== sv/mis_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the merge-insertion sorter, bound to the top level.
// Depends on mis_pkg and merge_insertion_sorter.
module mis_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic                               s_axis_tlast,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic signed [mis_pkg::VALUE_W-1:0] m_axis_tdata,
  input logic                               m_axis_tlast,
  input logic                               m_axis_tuser
);
  import mis_pkg::*;

  // Loading and sending never overlap
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a result is offered");

  // Last input word closes the load phase
  a_load_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input still ready after last word of set");

  // Last result returns the block to loading
  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> (!m_axis_tvalid && s_axis_tready))
    else $error("block not back to loading after last result");

  // A taken result is never followed at once by another offered result
  a_result_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready) |=> !m_axis_tvalid)
    else $error("result offered in the cycle after one was taken");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind merge_insertion_sorter mis_checker u_mis_checker (.*);

// ===== dv/merge_insertion_sorter_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for merge_insertion_sorter: streams value sets in and
// checks every sorted run word against an ascending-order model of the set.
// Depends on mis_pkg and the merge_insertion_sorter RTL.
module merge_insertion_sorter_tb;
  import mis_pkg::*;

  localparam int CAPACITY   = MAX_ITEMS_DEF;
  localparam int IDLE_LIMIT = 100000;
  localparam int RANDOM_ITEMS = 180;

  // One word of a sorted run as it should leave m_axis
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
    logic                      overflowed;
  } sorted_word_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic signed [VALUE_W-1:0] s_axis_tdata;   // [31:0] item_value
  logic                      s_axis_tlast;   // last_item
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  logic signed [VALUE_W-1:0] m_axis_tdata;   // [31:0] sorted_value
  logic                      m_axis_tlast;   // last_of_run
  logic                      m_axis_tuser;   // [0] overflowed

  // Model of the set being loaded
  logic signed [VALUE_W-1:0] set_values [CAPACITY];
  int                        set_len = 0;
  logic                      set_overflowed = 1'b0;
  sorted_word_t              expected_words [$];

  int   mismatch_count = 0;
  int   items_sent = 0;
  int   burst_left = 0;
  bit   gaps_on = 1'b1;
  int   idle_cycles = 0;
  logic [15:0] stall_pattern = '1;
  logic [3:0]  stall_phase = '0;

  merge_insertion_sorter #(
    .MAX_ITEMS(CAPACITY)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  // Load accepted words; on the last one, order the set and queue its run.
  // Merge-insertion leaves the run ascending, so an insertion sort of the
  // same values predicts it word for word.
  always @(posedge clk_i) begin : predict_sorted_run
    logic signed [VALUE_W-1:0] key;
    int i;
    int j;
    sorted_word_t next_word;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      if (set_len < CAPACITY) begin
        set_values[set_len] = s_axis_tdata;
        set_len++;
      end else begin
        set_overflowed = 1'b1;
      end
      if (s_axis_tlast) begin
        for (i = 1; i < set_len; i++) begin
          key = set_values[i];
          j = i - 1;
          while (j >= 0 && set_values[j] > key) begin
            set_values[j + 1] = set_values[j];
            j--;
          end
          set_values[j + 1] = key;
        end
        for (i = 0; i < set_len; i++) begin
          next_word = '{value: set_values[i], last: (i == set_len - 1),
                        overflowed: set_overflowed};
          expected_words = {expected_words, next_word};
        end
        set_len = 0;
        set_overflowed = 1'b0;
      end
    end
  end

  // Compare each taken result word with the oldest expected one
  always @(posedge clk_i) begin : check_sorted_run
    sorted_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_words.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected word, expected none, actual value %0d last %b ovf %b",
                 $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
      end else begin
        want = expected_words.pop_front();
        if (m_axis_tdata !== want.value) begin
          mismatch_count++;
          $display("%0t: sorted_value expected %0d actual %0d",
                   $time, want.value, m_axis_tdata);
        end
        if (m_axis_tlast !== want.last) begin
          mismatch_count++;
          $display("%0t: last_of_run expected %b actual %b", $time, want.last, m_axis_tlast);
        end
        if (m_axis_tuser !== want.overflowed) begin
          mismatch_count++;
          $display("%0t: overflowed expected %b actual %b",
                   $time, want.overflowed, m_axis_tuser);
        end
      end
    end
  end

  // Receiver stalls follow a random 16-bit pattern, reloaded each lap; some laps never stall
  always @(posedge clk_i) begin
    if (stall_phase == '0) begin
      stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= stall_pattern[stall_phase];
    end
    stall_phase <= stall_phase + 4'd1;
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Send one word; the sender runs in bursts with random gaps between them while gaps_on is set
  task automatic send_word(input logic signed [VALUE_W-1:0] value, input logic last);
    if (burst_left == 0) begin
      if (gaps_on) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
    items_sent++;
  endtask

  // Random value, weighted toward extremes and narrow ranges with duplicates
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      6, 7:    return VALUE_W'($signed($urandom_range(0, 16)) - 8);
      8:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      9:       return $urandom_range(0, 1) ? 32'sh0 : -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_set(input int len);
    for (int i = 0; i < len; i++) send_word(pick_value(), i == len - 1);
  endtask

  // Step past the edge of the last accepted word, then wait for its run to leave
  task automatic wait_run_done();
    do @(posedge clk_i); while (expected_words.size() != 0);
  endtask

  // Single-word set, extremes, bit patterns, duplicates, sorted and reversed input
  task automatic test_edge_sets();
    send_word(32'sh8000_0000, 1'b1);
    send_word(32'sh7FFF_FFFF, 1'b0);
    send_word(32'sh8000_0000, 1'b0);
    send_word(32'sh0, 1'b0);
    send_word(-32'sd1, 1'b0);
    send_word(32'sh5555_5555, 1'b0);
    send_word(32'shAAAA_AAAA, 1'b1);
    send_word(32'sd7, 1'b0);
    send_word(32'sd7, 1'b1);
    for (int i = 6; i > 0; i--) send_word(VALUE_W'(i * 1000 - 3000), i == 1);
    for (int i = 0; i < 4; i++) send_word(VALUE_W'(i - 2), i == 3);
  endtask

  // Exactly full set, then a set whose extra words and last word are dropped,
  // then a short set to see the overflow flag cleared
  task automatic test_capacity();
    send_random_set(CAPACITY);
    send_random_set(CAPACITY + 2);
    send_random_set(3);
  endtask

  // Hold the sender off until the whole run has left, then start a new set
  task automatic test_drain_pause();
    send_random_set(9);
    s_axis_tvalid <= 1'b0;
    wait_run_done();
    @(posedge clk_i);
    send_random_set(5);
  endtask

  // Random sets, mostly short, a few large and a few past capacity
  task automatic test_random_sets();
    int target;
    int len;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 19))
        0:       len = $urandom_range(CAPACITY + 1, CAPACITY + 6);
        1, 2:    len = $urandom_range(17, CAPACITY);
        default: len = $urandom_range(1, 16);
      endcase
      send_random_set(len);
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_edge_sets();
    test_capacity();
    test_drain_pause();
    test_random_sets();

    s_axis_tvalid <= 1'b0;
    wait_run_done();
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== merge_insertion_sorter.f =====
sv/mis_pkg.sv
sv/mis_datapath.sv
sv/mis_ctrl.sv
sv/merge_insertion_sorter.sv
sv/mis_checker.sv
dv/merge_insertion_sorter_tb.sv
